@@ rtl/mkrs_pkg.sv @@
package mkrs_pkg;

  localparam int IdW    = 30;
  localparam int ScoreW = 7;
  localparam int TotalW = 9;
  localparam int KeyW   = TotalW + 4 * ScoreW;

  // One stored record as it travels along the chain.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [KeyW-1:0]   key;   // total, score1 .. score4 from the top down
  } rec_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic insert;   // place the new record into the sorted chain
    logic shift;    // move every record one cell toward the head
    logic desc;     // descending key order
  } cell_ctrl_t;

  typedef enum logic [0:0] {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // True if record a must leave strictly before record b.
  function automatic logic goes_before(input rec_t a, input rec_t b, input logic desc);
    logic r;
    if (a.key != b.key) begin
      r = desc ? (a.key > b.key) : (a.key < b.key);
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

endpackage

@@ rtl/mkrs_cell.sv @@
module mkrs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mkrs_pkg::cell_ctrl_t ctrl_i,
  input  mkrs_pkg::rec_t     new_i,        // record being inserted
  input  mkrs_pkg::rec_t     prev_rec_i,   // record of the cell toward the head
  input  logic               prev_valid_i,
  input  logic               prev_take_i,  // previous cell takes the new record or shifted
  input  mkrs_pkg::rec_t     next_rec_i,   // record of the cell toward the tail
  input  logic               next_valid_i,
  output mkrs_pkg::rec_t     rec_o,
  output logic               valid_o,
  output logic               take_o
);
  import mkrs_pkg::*;

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;
  logic beats;

  // New record goes ahead of this one (empty cells always yield).
  assign beats  = !valid_q || goes_before(new_i, rec_q, ctrl_i.desc);
  assign take_o = beats;

  // Insert: cells before the slot hold, the slot takes the new record,
  // cells after it take their predecessor's record.
  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (prev_take_i) begin
        rec_d   = prev_rec_i;
        valid_d = prev_valid_i;
      end else if (beats) begin
        rec_d   = new_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      rec_d   = next_rec_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

@@ rtl/multi_key_record_sorter.sv @@
// Multi-key record sorter.
// Records enter on the s_axis channel, one item per cycle while loading:
// tdata holds id, score1..score4 and tlast closes the set. Each record drops
// straight into its sorted place in a chain of MAX_RECORDS cells, every cell
// comparing the new record against its own in the same cycle.
// After the item with tlast is taken the block stops accepting and emits the
// sorted records on m_axis, one item per cycle; tdata holds id, total and the
// four scores, tuser the dropped flag, and tlast marks the final record.
// The first result is ready in the cycle after the last item is taken. A stall
// on m_axis simply holds the head record; the chain shifts only on an accepted
// result item. Records beyond MAX_RECORDS are dropped and flag every result of
// their set. A set whose last record is dropped still emits its stored records.
// The sort_descending bit (cfg_wdata_i) selects the key order and is written via
// cfg_we_i while idle; the user must keep to this, the block does not enforce it.
// Reset empties the chain and clears the mode to ascending.
module multi_key_record_sorter #(
  parameter int MAX_RECORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,          // sort_descending
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,         // id, score1, score2, score3, score4
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,         // id, total, score1..score4
  output logic        m_axis_tlast,
  output logic        m_axis_tuser          // dropped
);
  import mkrs_pkg::*;

  localparam int CntW = $clog2(MAX_RECORDS + 1);

  state_e state_q, state_d;
  logic desc_q;
  logic [CntW-1:0] count_q, count_d;
  logic drop_q, drop_d;
  cell_ctrl_t ctrl;
  rec_t new_rec;
  logic in_acc, out_acc, full;

  rec_t rec   [MAX_RECORDS+1];
  logic valid [MAX_RECORDS+1];
  logic take  [MAX_RECORDS+1];

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign full    = count_q == CntW'(MAX_RECORDS);

  // Build the incoming record and its key.
  always_comb begin
    logic [TotalW-1:0] tot;
    tot = TotalW'(s_axis_tdata[36:30]) + TotalW'(s_axis_tdata[43:37])
        + TotalW'(s_axis_tdata[50:44]) + TotalW'(s_axis_tdata[57:51]);
    new_rec.id  = s_axis_tdata[29:0];
    new_rec.key = {tot, s_axis_tdata[36:30], s_axis_tdata[43:37],
                   s_axis_tdata[50:44], s_axis_tdata[57:51]};
  end

  // Ends of the chain: nothing shifts in from either side.
  assign rec[MAX_RECORDS]   = new_rec;
  assign valid[MAX_RECORDS] = 1'b0;
  assign take[0]            = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
      logic prev_take;
      rec_t prev_rec;
      logic prev_valid;
      if (g == 0) begin : g_head
        assign prev_take  = 1'b0;
        assign prev_rec   = new_rec;
        assign prev_valid = 1'b0;
      end else begin : g_body
        assign prev_take  = take[g];
        assign prev_rec   = rec[g-1];
        assign prev_valid = valid[g-1];
      end
      logic tk;
      mkrs_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .new_i        (new_rec),
        .prev_rec_i   (prev_rec),
        .prev_valid_i (prev_valid),
        .prev_take_i  (prev_take),
        .next_rec_i   (rec[g+1]),
        .next_valid_i (valid[g+1]),
        .rec_o        (rec[g]),
        .valid_o      (valid[g]),
        .take_o       (tk)
      );
      // The chain is kept sorted, so once the new record beats a cell it
      // beats every later one; cell g+1 shifts exactly when cell g yields.
      assign take[g+1] = tk;
    end
  endgenerate

  // Sequencer for load and drain.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    ctrl.desc   = desc_q;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = count_q != '0;
        if (count_q == '0) begin
          state_d = ST_LOAD;
          drop_d  = 1'b0;
        end else if (out_acc) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - 1'b1;
          if (count_q == CntW'(1)) begin
            state_d = ST_LOAD;
            drop_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      desc_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
    end
  end

  // Head cell feeds the result item: id, total, then score1 up to score4.
  assign m_axis_tdata = {5'd0, rec[0].key[ScoreW-1:0], rec[0].key[2*ScoreW-1:ScoreW],
                         rec[0].key[3*ScoreW-1:2*ScoreW], rec[0].key[4*ScoreW-1:3*ScoreW],
                         rec[0].key[KeyW-1:4*ScoreW], rec[0].id};
  assign m_axis_tlast = count_q == CntW'(1);
  assign m_axis_tuser = drop_q;

  // A result is offered only while the head cell holds a record.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> valid[0]) else $error("head cell empty while emitting");

  // Loading never runs past capacity.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RECORDS)) else $error("record count beyond capacity");

  // The block never loads and emits at once.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("load and emit overlap");

endmodule

@@ tb/multi_key_record_sorter_test.sv @@
`timescale 1ns / 1ps

module multi_key_record_sorter_test;

  localparam int MaxRecords = 64;
  localparam int CycleLimit = 400000;

  // One record as the sender presents it.
  typedef struct {
    logic [29:0] id;
    logic [6:0]  s1, s2, s3, s4;
    logic        last;
  } rec_in_t;

  // One sorted record as the block should emit it.
  typedef struct {
    logic [29:0] id;
    logic [8:0]  total;
    logic [6:0]  s1, s2, s3, s4;
    logic        last;
    logic        dropped;
  } rec_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // id, score1, score2, score3, score4
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;    // id, total, score1..score4
  logic        m_axis_tlast;
  logic        m_axis_tuser;    // dropped

  multi_key_record_sorter #(.MAX_RECORDS(MaxRecords)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  rec_in_t  pending_records[$];
  rec_out_t sorted_expected[$];
  rec_in_t  set_buffer[$];
  logic     set_overflow;
  logic     mode_desc;
  int       errors;
  int       cycles;
  int       results_seen;
  int       sets_sent;
  bit       quiet;
  bit       in_took;
  int       src_gap;
  int       snk_gap;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [36:0] sort_key(rec_in_t r);
    return {9'(r.s1) + 9'(r.s2) + 9'(r.s3) + 9'(r.s4), r.s1, r.s2, r.s3, r.s4};
  endfunction

  function automatic bit ranks_first(rec_in_t a, rec_in_t b, logic desc);
    logic [36:0] ka, kb;
    ka = sort_key(a);
    kb = sort_key(b);
    if (ka != kb) return desc ? (ka > kb) : (ka < kb);
    return a.id < b.id;
  endfunction

  // Track one accepted record and, on the last one, queue the sorted set.
  task automatic absorb_record(rec_in_t r);
    rec_in_t  order[$];
    rec_out_t o;
    int       j;
    if (set_buffer.size() < MaxRecords) set_buffer.push_back(r);
    else set_overflow = 1'b1;
    if (!r.last) return;
    foreach (set_buffer[i]) begin
      j = order.size();
      while (j > 0 && ranks_first(set_buffer[i], order[j-1], mode_desc)) j--;
      order.insert(j, set_buffer[i]);
    end
    foreach (order[i]) begin
      o.id = order[i].id;
      o.total = 9'(sort_key(order[i]) >> 28);
      o.s1 = order[i].s1; o.s2 = order[i].s2; o.s3 = order[i].s3; o.s4 = order[i].s4;
      o.last = (i == order.size() - 1);
      o.dropped = set_overflow;
      sorted_expected.push_back(o);
    end
    set_buffer.delete();
    set_overflow = 1'b0;
  endtask

  // Driver: presents pending records with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_records.size() > 0 &&
                   !(in_took && !quiet && $urandom_range(9) == 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, pending_records[0].s4, pending_records[0].s3,
                         pending_records[0].s2, pending_records[0].s1,
                         pending_records[0].id};
        s_axis_tlast <= pending_records[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (pending_records.size() > 0 && !quiet) src_gap <= $urandom_range(12);
      end
      // Receiver stalls in bursts.
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        snk_gap <= $urandom_range(12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: records accepted input and checks every result item.
  always @(posedge clk_i) begin
    rec_in_t  r;
    rec_out_t e;
    in_took = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_took) begin
      r.id = s_axis_tdata[29:0];
      r.s1 = s_axis_tdata[36:30]; r.s2 = s_axis_tdata[43:37];
      r.s3 = s_axis_tdata[50:44]; r.s4 = s_axis_tdata[57:51];
      r.last = s_axis_tlast;
      absorb_record(r);
      void'(pending_records.pop_front());
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (sorted_expected.size() == 0) begin
        $display("%0t unexpected result item %h", $time, m_axis_tdata);
        errors <= errors + 1;
      end else begin
        e = sorted_expected.pop_front();
        if (m_axis_tdata != {5'd0, e.s4, e.s3, e.s2, e.s1, e.total, e.id} ||
            m_axis_tlast != e.last || m_axis_tuser != e.dropped) begin
          $display("%0t mismatch: expected id %0d total %0d s %0d %0d %0d %0d last %b drop %b",
                   $time, e.id, e.total, e.s1, e.s2, e.s3, e.s4, e.last, e.dropped);
          $display("%0t   actual id %0d total %0d s %0d %0d %0d %0d last %b drop %b",
                   $time, m_axis_tdata[29:0], m_axis_tdata[38:30], m_axis_tdata[45:39],
                   m_axis_tdata[52:46], m_axis_tdata[59:53], m_axis_tdata[66:60],
                   m_axis_tlast, m_axis_tuser);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic queue_record(logic [29:0] id, logic [6:0] a, b, c, d, logic last);
    rec_in_t r;
    r.id = id; r.s1 = a; r.s2 = b; r.s3 = c; r.s4 = d; r.last = last;
    pending_records.push_back(r);
    if (last) sets_sent++;
  endtask

  function automatic logic [6:0] rand_score();
    case ($urandom_range(5))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'($urandom_range(127));
      default: return 7'($urandom_range(100));
    endcase
  endfunction

  // Queue a set of random records; small values give plenty of ties.
  task automatic queue_random_set(int n);
    logic [29:0] id;
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(3) == 0) ? 30'($urandom) : 30'($urandom_range(20));
      if ($urandom_range(2) == 0)
        queue_record(id, 7'($urandom_range(2)), 7'($urandom_range(2)),
                     7'($urandom_range(2)), 7'($urandom_range(2)), i == n - 1);
      else
        queue_record(id, rand_score(), rand_score(), rand_score(), rand_score(), i == n - 1);
    end
  endtask

  // Wait for the block to drain, then write the mode register.
  task automatic set_mode(logic desc);
    while (pending_records.size() > 0 || s_axis_tvalid || sorted_expected.size() > 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= desc;
    mode_desc = desc;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    set_overflow = 1'b0;
    mode_desc = 1'b0;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    sets_sent = 0;
    quiet = 1'b0;
    in_took = 1'b0;
    src_gap = 0;
    snk_gap = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, ties, a single record, out-of-range values.
    set_mode(1'b0);
    queue_record(30'd5, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
    queue_record(30'h3FFFFFFF, 7'd127, 7'd127, 7'd127, 7'd127, 1'b0);
    queue_record(30'd999999999, 7'd100, 7'd100, 7'd100, 7'd100, 1'b0);
    queue_record(30'd7, 7'd1, 7'd2, 7'd3, 7'd4, 1'b0);
    queue_record(30'd3, 7'd1, 7'd2, 7'd3, 7'd4, 1'b0);
    queue_record(30'd3, 7'd1, 7'd2, 7'd3, 7'd4, 1'b0);
    queue_record(30'd9, 7'd4, 7'd3, 7'd2, 7'd1, 1'b0);
    queue_record(30'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
    set_mode(1'b1);
    queue_record(30'd1, 7'd10, 7'd0, 7'd0, 7'd0, 1'b0);
    queue_record(30'd2, 7'd0, 7'd10, 7'd0, 7'd0, 1'b0);
    queue_record(30'd4, 7'd0, 7'd0, 7'd0, 7'd10, 1'b0);
    queue_record(30'd0, 7'd127, 7'd0, 7'd127, 7'd0, 1'b1);
    // Overflow: a full store, then dropped records, the last one dropped too.
    queue_random_set(MaxRecords + 3);

    // Random small sets in either key order.
    for (int k = 0; k < 12; k++) begin
      set_mode(1'($urandom_range(1)));
      queue_random_set($urandom_range(1, 12));
    end
    quiet = 1'b1;
    for (int k = 0; k < 3; k++) queue_random_set($urandom_range(1, 8));

    while (pending_records.size() > 0 || s_axis_tvalid || sorted_expected.size() > 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d sets in both key orders, including full and overflowing sets;",
             sets_sent);
    $display("checked %0d sorted result items.", results_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mkrs_pkg.sv
rtl/mkrs_cell.sv
rtl/multi_key_record_sorter.sv
tb/multi_key_record_sorter_test.sv
